/* hdl/wmtd_pkg.sv */
// Package for the windowed mean threshold detector.
// Holds field widths, input and register codes and the control state type.
// No dependencies.
package wmtd_pkg;

    localparam int PROB_W    = 8;
    localparam int WLEN_W    = 5;
    localparam int CUTOFF_W  = 8;
    localparam int OSUM_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [WLEN_W-1:0]   WLEN_RESET   = 5'd5;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 8'd200;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_PROB_CUTOFF   = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [PROB_W-1:0] data;
    } t_cell_wr;

endpackage

/* hdl/wmtd_cell.sv */
// One cell of the detector's row: stores one probability and, while it
// is in the window, adds it to the partial sum moving left to right.
// Depends on wmtd_pkg.
module wmtd_cell
    import wmtd_pkg::*;
#(
    parameter int CELL_POS = 0,
    parameter int WIN_W    = 5,
    parameter int SUM_W    = 13
) (
    input  logic             i_clk,
    input  t_cell_wr         i_wr,
    input  logic [WIN_W-1:0] i_win,
    input  logic [SUM_W-1:0] i_sum,
    output logic [SUM_W-1:0] o_sum
);

    logic [PROB_W-1:0] r_entry;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic              active;

    assign active = (CELL_POS < int'(i_win));

    always_comb begin
        n_sum = i_sum;
        if (active) begin
            n_sum = i_sum + SUM_W'(r_entry);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_entry <= i_wr.data;
        end
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

/* hdl/windowed_mean_threshold_detector.sv */
// Top level of the windowed mean threshold detector.
// Depends on wmtd_pkg and wmtd_cell.
//
// Usage:
// The slave stream carries one item per transfer: tdata holds the probability
// and tuser the kind (sample or clear). The master stream returns one result
// per item, but none for a clear or non-filling sample taken with i_cfg_we
// high. Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data
// while the block is idle; writing the window length empties the window.
// A clear item, and a sample that leaves the window not yet full, give their
// result in the register in the cycle after the transfer. A sample that fills
// the window waits while the partial sum travels through the row of MAX_WINDOW
// cells, one cell per cycle, counted in state ST_SUM; its result is registered
// in ST_DONE, and the next item is taken only once the block is back in ST_IDLE.
// One item is in work at a time. A new item is taken while the previous
// result is being transferred; while the receiver stalls, the result holds
// and no new item is taken.
// Reset sets the window length to 5, the cutoff to 200 and empties the
// window; stored probabilities are only read after they are written again.
module windowed_mean_threshold_detector
    import wmtd_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Bits from low: probability [7:0].
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Bits from low: kind [0].
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Bits from low: detected [0], window_sum [12:1], window_full [13],
    // latest_probability [21:14], zero fill [23:22].
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = PROB_W + WIN_W;

    t_state              r_state, n_state;
    logic [WLEN_W-1:0]   r_wlen;
    logic [CUTOFF_W-1:0] r_cutoff;
    logic [IDX_W-1:0]    r_idx;
    logic [WIN_W-1:0]    r_fill;
    logic [PROB_W-1:0]   r_last;
    logic [WIN_W-1:0]    r_cnt;
    logic                r_ovalid;
    logic                n_ovalid;
    logic                r_odet;
    logic [OSUM_W-1:0]   r_osum;
    logic                r_ofull;
    logic [PROB_W-1:0]   r_olast;

    logic [WIN_W-1:0]    win;
    logic [WIN_W-1:0]    idx_eff;
    logic [WIN_W-1:0]    idx_inc;
    logic [WIN_W-1:0]    fill_inc;
    logic                in_xfer;
    logic                is_clear;
    logic [SUM_W-1:0]    limit;
    logic [SUM_W-1:0]    sum_final;
    logic                over;
    t_cell_wr            cell_wr [MAX_WINDOW];
    logic [SUM_W-1:0]    chain [MAX_WINDOW+1];

    always_comb begin
        if (r_wlen == '0) begin
            win = WIN_W'(1);
        end else if (int'(r_wlen) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = WIN_W'(r_wlen);
        end
    end

    assign idx_eff  = (WIN_W'(r_idx) >= win) ? '0 : WIN_W'(r_idx);
    assign idx_inc  = ((idx_eff + WIN_W'(1)) == win) ? '0 : (idx_eff + WIN_W'(1));
    assign fill_inc = (r_fill < win) ? (r_fill + WIN_W'(1)) : r_fill;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_clear      = (t_kind'(s_axis_tuser) == KIND_CLEAR);

    assign chain[0] = '0;
    generate
        for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
            assign cell_wr[k].wr_en = in_xfer && !is_clear && (idx_eff == WIN_W'(k));
            assign cell_wr[k].data  = s_axis_tdata[PROB_W-1:0];

            wmtd_cell #(
                .CELL_POS (k),
                .WIN_W    (WIN_W),
                .SUM_W    (SUM_W)
            ) u_cell (
                .i_clk (i_clk),
                .i_wr  (cell_wr[k]),
                .i_win (win),
                .i_sum (chain[k]),
                .o_sum (chain[k+1])
            );
        end
    endgenerate

    assign sum_final = chain[MAX_WINDOW];
    assign limit     = SUM_W'(r_cutoff) * SUM_W'(win);
    assign over      = (sum_final > limit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && !is_clear && (fill_inc >= win)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_cnt == WIN_W'(MAX_WINDOW - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid && !m_axis_tready;
        if (in_xfer && !i_cfg_we && (is_clear || (fill_inc < win))) begin
            n_ovalid = 1'b1;
        end
        if (r_state == ST_DONE) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen   <= WLEN_RESET;
            r_cutoff <= CUTOFF_RESET;
            r_idx    <= '0;
            r_fill   <= '0;
            r_last   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (r_state == ST_SUM) begin
                r_cnt <= r_cnt + WIN_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_WINDOW_LENGTH: begin
                        r_wlen <= i_cfg_data[WLEN_W-1:0];
                        r_idx  <= '0;
                        r_fill <= '0;
                    end
                    REG_PROB_CUTOFF: begin
                        r_cutoff <= i_cfg_data[CUTOFF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (in_xfer) begin
                if (is_clear) begin
                    r_idx  <= '0;
                    r_fill <= '0;
                    r_last <= '0;
                end else begin
                    r_idx  <= IDX_W'(idx_inc);
                    r_fill <= fill_inc;
                    r_last <= s_axis_tdata[PROB_W-1:0];
                end
            end else if ((r_state == ST_DONE) && over) begin
                r_idx  <= '0;
                r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_odet  <= 1'b0;
            r_osum  <= '0;
            r_ofull <= 1'b0;
            r_olast <= is_clear ? '0 : s_axis_tdata[PROB_W-1:0];
        end else if (r_state == ST_DONE) begin
            r_odet  <= over;
            r_osum  <= sum_final[OSUM_W-1:0];
            r_ofull <= 1'b1;
            r_olast <= r_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_olast, r_ofull, r_osum, r_odet};

endmodule
